FILE: rtl/core/simulated_time_barrier_top_macros.svh
// assertion macros used by the bound checker stb_checker
`ifndef SIMULATED_TIME_BARRIER_TOP_MACROS_SVH
`define SIMULATED_TIME_BARRIER_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define STB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define STB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    // table size and derived widths
    localparam int PARTICIPANTS = 16;
    localparam int PIDX_W       = (PARTICIPANTS > 1) ? $clog2(PARTICIPANTS) : 1;
    localparam int CNT_W        = $clog2(PARTICIPANTS + 1);

    localparam logic [63:0] ONE_SECOND_NS = 64'd1000000000;
    localparam logic [63:0] STOP_SYMBOL   = 64'hFFFF_FFFF_FFFF_FFFF;

    // item function codes
    localparam logic [1:0] FUNC_REPORT = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_STOP   = 2'd2;

    // participant classes
    localparam logic [1:0] CLS_WORKING  = 2'd0;
    localparam logic [1:0] CLS_OUT_SYNC = 2'd1;
    localparam logic [1:0] CLS_WAITING  = 2'd2;
    localparam logic [1:0] CLS_REALTIME = 2'd3;

    // barrier check outcomes
    localparam logic [1:0] CHK_NONE     = 2'd0;
    localparam logic [1:0] CHK_ADVANCED = 2'd1;
    localparam logic [1:0] CHK_NO_DATA  = 2'd2;
    localparam logic [1:0] CHK_OUT_SYNC = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  participant;
        logic [63:0] next_stamp;
        logic [63:0] now_time;
    } stb_in_t;

    typedef struct packed {
        logic        trigger_valid;
        logic        trigger_stop;
        logic [63:0] trigger_stamp;
        logic        report_stored;
        logic [1:0]  participant_state;
        logic [1:0]  check_result;
        logic [63:0] current_time;
    } stb_out_t;

    // write request into the stamp table
    typedef struct packed {
        logic              en;
        logic [PIDX_W-1:0] addr;
        logic [63:0]       data;
    } stb_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/stb_table.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_table (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire stb_pkg::stb_wr_t                 wr,
    input  wire logic [stb_pkg::PIDX_W-1:0]       rd_addr,
    output logic [63:0]                           rd_data,
    output logic [stb_pkg::PARTICIPANTS-1:0]      valid
);
    import stb_pkg::*;

    logic [63:0]             mem [PARTICIPANTS];
    logic [63:0]             rd_data_reg;
    logic [PARTICIPANTS-1:0] valid_reg;
    logic [PARTICIPANTS-1:0] valid_next;

    // entry valid bits, cleared by reset
    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stamp memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/simulated_time_barrier_top.sv
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall   in_data   (stb_in_t)
// out       source     out_valid / out_stall out_data  (stb_out_t)
// cfg       sink       cfg_valid / cfg_ready cfg_data  (simulated_mode)
//
// a report or start in simulated mode (a report only once a start was seen)
// passes S_READ, S_UPD, S_SCAN (the scan of the stamp table through its
// single read port), S_DECIDE and S_DONE, which loads the result once the
// output register is free; other items skip S_SCAN and S_DECIDE
// reset clears the entry valid bits at once, there is no clearing pass
// a stalled result holds in the output register while the next item is taken
`timescale 1ns / 1ps
`default_nettype none

module simulated_time_barrier_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire stb_pkg::stb_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output stb_pkg::stb_out_t     out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data
);
    import stb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    stb_in_t           item_reg, item_next;
    stb_out_t          res_reg, res_next;
    stb_out_t          out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;
    logic              mode_reg, mode_next;
    logic              running_reg, running_next;
    logic [63:0]       sim_time_reg, sim_time_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [PIDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [63:0]       best_reg, best_next;
    logic              found_reg, found_next;

    stb_wr_t                 wr;
    logic [PIDX_W-1:0]       rd_addr;
    logic [63:0]             rd_data;
    logic [PARTICIPANTS-1:0] valid;

    logic [PIDX_W-1:0] who;
    logic              in_range;
    logic [63:0]       held;
    logic              store;
    logic              do_check;
    logic [1:0]        cls;

    stb_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .valid   (valid)
    );

    // report decode against the held entry
    always_comb
    begin
        who      = PIDX_W'(item_reg.participant);
        in_range = (9'(item_reg.participant) < 9'(PARTICIPANTS));
        held     = valid[who] ? rd_data : 64'd0;
        store    = (item_reg.func == FUNC_REPORT) && in_range
                   && (item_reg.next_stamp >= held);
        if (!mode_reg)
        begin
            cls = CLS_REALTIME;
        end
        else if (item_reg.next_stamp == sim_time_reg)
        begin
            cls = CLS_WORKING;
        end
        else if (item_reg.next_stamp < sim_time_reg)
        begin
            cls = CLS_OUT_SYNC;
        end
        else
        begin
            cls = CLS_WAITING;
        end
        running_next = running_reg;
        if ((state_reg == S_UPD) && (item_reg.func == FUNC_START))
        begin
            running_next = 1'b1;
        end
        do_check = ((item_reg.func == FUNC_REPORT)
                    || ((item_reg.func == FUNC_START) && mode_reg))
                   && mode_reg && (running_reg || (item_reg.func == FUNC_START));
    end

    // table access
    always_comb
    begin
        wr.en   = (state_reg == S_UPD) && store;
        wr.addr = who;
        wr.data = item_reg.next_stamp;
        rd_addr = (state_reg == S_SCAN) ? scan_reg[PIDX_W-1:0] : who;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        sim_time_next = sim_time_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        mode_next     = cfg_valid ? cfg_data : mode_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                res_next = '0;
                if (store)
                begin
                    res_next.report_stored     = 1'b1;
                    res_next.participant_state = cls;
                end
                if ((item_reg.func == FUNC_START) && !mode_reg)
                begin
                    res_next.trigger_valid = 1'b1;
                    res_next.trigger_stamp = item_reg.now_time + ONE_SECOND_NS;
                end
                if (item_reg.func == FUNC_STOP)
                begin
                    res_next.trigger_valid = 1'b1;
                    res_next.trigger_stop  = 1'b1;
                    res_next.trigger_stamp = STOP_SYMBOL;
                end
                scan_next  = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
                state_next = do_check ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                // issue one read a cycle, compare the one returned
                if (scan_reg != CNT_W'(PARTICIPANTS))
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[PIDX_W-1:0];
                    scan_next     = scan_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && valid[pend_idx_reg] && (!found_reg || (rd_data < best_reg)))
                begin
                    best_next  = rd_data;
                    found_next = 1'b1;
                end
                if ((scan_reg == CNT_W'(PARTICIPANTS)) && !pend_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!found_reg)
                begin
                    res_next.check_result = CHK_NO_DATA;
                end
                else if (best_reg < sim_time_reg)
                begin
                    res_next.check_result = CHK_OUT_SYNC;
                end
                else
                begin
                    sim_time_next          = best_reg;
                    res_next.check_result  = CHK_ADVANCED;
                    res_next.trigger_valid = 1'b1;
                    res_next.trigger_stop  = 1'b0;
                    res_next.trigger_stamp = best_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next              = res_reg;
                    out_data_next.current_time = sim_time_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            running_reg   <= 1'b0;
            sim_time_reg  <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            running_reg   <= running_next;
            sim_time_reg  <= sim_time_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/core/stb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "simulated_time_barrier_top_macros.svh"

module stb_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire stb_pkg::stb_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire stb_pkg::stb_out_t out_data,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              cfg_data
);
    import stb_pkg::*;

    logic [63:0] last_time_reg;
    logic        out_xfer;
    logic        in_xfer;

    assign out_xfer = out_valid && !out_stall;
    assign in_xfer  = in_valid && !in_stall;

    // simulated time of the last result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else if (out_xfer)
        begin
            last_time_reg <= out_data.current_time;
        end
    end

    // a stalled result holds
    `STB_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

    // simulated time never steps back
    `STB_ASSERT_IMP(a_time_mono, out_xfer, out_data.current_time >= last_time_reg, "simulated time went backwards")

    // an advance carries the new time in its trigger
    `STB_ASSERT_IMP(a_adv_trig, out_xfer && (out_data.check_result == CHK_ADVANCED), out_data.trigger_valid && !out_data.trigger_stop && (out_data.trigger_stamp == out_data.current_time), "advance without matching trigger")

    // one item in work at a time
    `STB_ASSERT_NXT(a_busy, in_xfer, in_stall, "input taken while busy")

endmodule

bind simulated_time_barrier_top stb_checker u_stb_checker (.*);

`default_nettype wire

FILE: sim/stb_barrier_checker.sv
`timescale 1ns / 1ps

module stb_barrier_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire stb_pkg::stb_in_t  in_data,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire stb_pkg::stb_out_t out_data,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic              cfg_data,
    output int                     errors,
    output int                     outstanding
);

    import stb_pkg::*;

    // own copy of the barrier state
    bit          sim_mode;
    bit          slot_valid [PARTICIPANTS];
    logic [63:0] slot_stamp [PARTICIPANTS];
    logic [63:0] sim_clock;
    bit          started;

    stb_out_t    awaited_results[$];
    int          mismatches;

    // smallest held stamp decides whether simulated time may advance
    task automatic run_barrier(inout stb_out_t res);
        logic [63:0] lowest;
        bit          found;
        lowest = '0;
        found  = 1'b0;
        if (!(sim_mode && started)) begin
            res.check_result = CHK_NONE;
        end
        else begin
            for (int k = 0; k < PARTICIPANTS; k++) begin
                if (slot_valid[k] && (!found || slot_stamp[k] < lowest)) begin
                    lowest = slot_stamp[k];
                    found  = 1'b1;
                end
            end
            if (!found) begin
                res.check_result = CHK_NO_DATA;
            end
            else if (lowest < sim_clock) begin
                res.check_result = CHK_OUT_SYNC;
            end
            else begin
                sim_clock          = lowest;
                res.trigger_valid  = 1'b1;
                res.trigger_stop   = 1'b0;
                res.trigger_stamp  = lowest;
                res.check_result   = CHK_ADVANCED;
            end
        end
    endtask

    // expected result of one accepted item, updating the barrier state
    task automatic predict_barrier_item(input stb_in_t item, output stb_out_t res);
        logic [63:0] held;
        int          who;
        res = '0;
        who = int'(item.participant);
        case (item.func)
            FUNC_REPORT:
            begin
                if (who < PARTICIPANTS) begin
                    held = slot_valid[who] ? slot_stamp[who] : 64'd0;
                    if (item.next_stamp >= held) begin
                        if (!sim_mode)
                            res.participant_state = CLS_REALTIME;
                        else if (item.next_stamp == sim_clock)
                            res.participant_state = CLS_WORKING;
                        else if (item.next_stamp < sim_clock)
                            res.participant_state = CLS_OUT_SYNC;
                        else
                            res.participant_state = CLS_WAITING;
                        slot_valid[who]   = 1'b1;
                        slot_stamp[who]   = item.next_stamp;
                        res.report_stored = 1'b1;
                    end
                end
                run_barrier(res);
            end
            FUNC_START:
            begin
                started = 1'b1;
                if (sim_mode) begin
                    run_barrier(res);
                end
                else begin
                    res.trigger_valid = 1'b1;
                    res.trigger_stamp = item.now_time + ONE_SECOND_NS;
                end
            end
            FUNC_STOP:
            begin
                res.trigger_valid = 1'b1;
                res.trigger_stop  = 1'b1;
                res.trigger_stamp = STOP_SYMBOL;
            end
            default:
            begin
            end
        endcase
        res.current_time = sim_clock;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n) begin
        stb_out_t want;
        stb_out_t got;
        if (!rst_n) begin
            sim_mode   = 1'b0;
            sim_clock  = '0;
            started    = 1'b0;
            mismatches = 0;
            for (int k = 0; k < PARTICIPANTS; k++) begin
                slot_valid[k] = 1'b0;
                slot_stamp[k] = '0;
            end
            awaited_results.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else begin
            // register write
            if (cfg_valid && cfg_ready)
                sim_mode = cfg_data;

            // result transfer against the oldest expectation
            if (out_valid && !out_stall) begin
                got = out_data;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with none awaited: current_time %0h",
                                 got.current_time);
                end
                else begin
                    want = awaited_results.pop_front();
                    check_field("trigger_valid", 64'(want.trigger_valid),
                                64'(got.trigger_valid));
                    check_field("trigger_stop", 64'(want.trigger_stop),
                                64'(got.trigger_stop));
                    check_field("trigger_stamp", want.trigger_stamp, got.trigger_stamp);
                    check_field("report_stored", 64'(want.report_stored),
                                64'(got.report_stored));
                    check_field("participant_state", 64'(want.participant_state),
                                64'(got.participant_state));
                    check_field("check_result", 64'(want.check_result),
                                64'(got.check_result));
                    check_field("current_time", want.current_time, got.current_time);
                end
            end

            // item transfer
            if (in_valid && !in_stall) begin
                predict_barrier_item(in_data, want);
                awaited_results.push_back(want);
            end

            errors      <= mismatches;
            outstanding <= awaited_results.size();
        end
    end

endmodule

FILE: sim/simulated_time_barrier_top_tb.sv
`timescale 1ns / 1ps

module simulated_time_barrier_top_tb;

    import stb_pkg::*;

    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         IDLE_LIMIT   = 5000;
    localparam int         PHASE_ITEMS  = 172;
    localparam int         PHASES       = 6;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    stb_in_t  in_data   = '0;
    logic     out_stall = 1'b0;
    logic     cfg_valid = 1'b0;
    logic     cfg_data  = 1'b0;
    logic     in_stall;
    logic     out_valid;
    stb_out_t out_data;
    logic     cfg_ready;

    int       errors;
    int       outstanding;
    int       idle_cycles = 0;
    bit       hold_req    = 1'b0;
    int       burst_left  = 0;

    // stamps the table should hold, used only to shape the stimulus
    logic [63:0] held_stamp [PARTICIPANTS];
    bit          held_valid [PARTICIPANTS];

    bit phase_mode [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    simulated_time_barrier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stb_barrier_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int seg_len;
        int pct;
        forever begin
            seg_len = $urandom_range(10, 150);
            case ($urandom_range(0, 4))
                0, 1:    pct = 0;
                2:       pct = 25;
                3:       pct = 50;
                default: pct = 85;
            endcase
            for (int i = 0; i < seg_len; i++) begin
                @(posedge clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic stb_in_t make_item(logic [1:0] f, logic [3:0] who,
                                          logic [63:0] stamp, logic [63:0] now);
        stb_in_t it;
        it.func        = f;
        it.participant = who;
        it.next_stamp  = stamp;
        it.now_time    = now;
        return it;
    endfunction

    // mostly advancing reports, some stale ones and commands with random content
    function automatic stb_in_t random_item(int reach);
        stb_in_t     it;
        int          r;
        int          who;
        int          d;
        logic [63:0] base;
        logic [63:0] front;
        front = '0;
        for (int k = 0; k < PARTICIPANTS; k++)
            if (held_valid[k] && held_stamp[k] > front)
                front = held_stamp[k];
        r   = $urandom_range(0, 99);
        who = $urandom_range(0, reach);
        d   = $urandom_range(1, 1000);
        base = held_valid[who] ? held_stamp[who] : 64'd0;
        it = make_item(FUNC_REPORT, 4'(who), {$urandom, $urandom}, {$urandom, $urandom});
        if (r < 35)
            it.next_stamp = base + 64'($urandom_range(0, 40));
        else if (r < 62)
            it.next_stamp = front + 64'($urandom_range(0, 3));
        else if (r < 75)
            it.next_stamp = (base > 64'(d)) ? base - 64'(d) : 64'd0;
        else if (r < 85)
            it.func = FUNC_START;
        else if (r < 95)
            it.func = FUNC_STOP;
        else
            it.func = FUNC_UNUSED;
        return it;
    endfunction

    // one item transfer, in bursts with random gaps
    task automatic offer(input stb_in_t item);
        int gap;
        int who;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        who = int'(item.participant);
        if (item.func == FUNC_REPORT &&
            (!held_valid[who] || item.next_stamp >= held_stamp[who])) begin
            held_valid[who] = 1'b1;
            held_stamp[who] = item.next_stamp;
        end
    endtask

    // stop offering until every awaited result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_mode(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        int reach;
        int sent;
        for (int k = 0; k < PARTICIPANTS; k++) begin
            held_valid[k] = 1'b0;
            held_stamp[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // simulated mode: commands, empty table, stale and out-of-sync reports
        write_mode(1'b1);
        offer(make_item(FUNC_UNUSED, 4'hF, STOP_SYMBOL, STOP_SYMBOL));
        offer(make_item(FUNC_STOP, 4'h0, 64'd0, 64'd0));
        offer(make_item(FUNC_START, 4'h0, 64'd0, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h0, 64'd100, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h1, 64'd50, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h1, 64'd40, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h1, 64'd100, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h2, 64'd100, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h0, 64'd130, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h1, 64'd120, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h2, 64'd110, 64'd0));
        offer(make_item(FUNC_REPORT, 4'hF, STOP_SYMBOL, 64'd0));
        offer(make_item(FUNC_START, 4'h5, 64'd0, STOP_SYMBOL));
        offer(make_item(FUNC_STOP, 4'hA, STOP_SYMBOL, 64'd0));
        wait_drained();

        // realtime mode: one-second trigger with wrap, realtime class
        write_mode(1'b0);
        offer(make_item(FUNC_REPORT, 4'h3, 64'd0, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h3, 64'd0, 64'd0));
        offer(make_item(FUNC_START, 4'h0, 64'd0, 64'd0));
        offer(make_item(FUNC_START, 4'h0, 64'd0, STOP_SYMBOL));
        offer(make_item(FUNC_START, 4'h0, 64'd0, STOP_SYMBOL - ONE_SECOND_NS));
        offer(make_item(FUNC_STOP, 4'h0, 64'd0, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h4, 64'd5, 64'd0));
        offer(make_item(FUNC_REPORT, 4'h4, 64'd3, 64'd0));
        offer(make_item(FUNC_UNUSED, 4'h6, 64'd0, 64'd0));

        // random phases, participants joining over time
        sent = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_mode(phase_mode[ph]);
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                reach = 4 + sent / 50;
                if (reach > PARTICIPANTS - 1)
                    reach = PARTICIPANTS - 1;
                offer(random_item(reach));
                sent++;
            end
        end

        wait_drained();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: simulated_time_barrier_top.f
+incdir+rtl/core
rtl/core/stb_pkg.sv
rtl/core/stb_table.sv
rtl/core/simulated_time_barrier_top.sv
rtl/core/stb_checker.sv
sim/stb_barrier_checker.sv
sim/simulated_time_barrier_top_tb.sv
